/* design/sbma_pkg.sv */
// shared types and constants for the spi backup memory slave
package sbma_pkg;

	localparam int unsigned ADDR_W  = 24;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned RECIP_W = 26;
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = $clog2(QDEPTH);

	localparam logic [7:0] OP_IDLE  = 8'h00;
	localparam logic [7:0] OP_WRSR  = 8'h01;
	localparam logic [7:0] OP_WRITE = 8'h02;
	localparam logic [7:0] OP_READ  = 8'h03;
	localparam logic [7:0] OP_WRDI  = 8'h04;
	localparam logic [7:0] OP_RDSR  = 8'h05;
	localparam logic [7:0] OP_WREN  = 8'h06;
	localparam logic [7:0] OP_IRDA  = 8'h08;
	localparam logic [7:0] OP_WRHI  = 8'h0A;
	localparam logic [7:0] OP_RDHI  = 8'h0B;

	localparam logic [7:0] BYTE_ERASED   = 8'hFF;
	localparam logic [7:0] BYTE_IRDA     = 8'hAA;
	localparam logic [7:0] STATUS_MASK   = 8'hFC;
	localparam logic [7:0] STATUS_WEL    = 8'h02;
	localparam logic [ADDR_W-1:0] ADDR_ONE_BYTE_MASK = 24'h0001FF;

	typedef struct packed {
		logic       is_ctrl;
		logic [7:0] data;
		logic       hold_cs;
		logic       slot_mode;
		logic       word_zero;
	} item_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

/* design/sbma_front.sv */
// front end: input handshake and classification of each transfer
module sbma_front import sbma_pkg::*; (
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [WORD_W-1:0]   value_in,
	input  logic                hold_cs,
	input  logic                slot_mode,
	input  back_status_t        status,
	input  logic                q_full,
	output logic                q_push,
	output item_t               q_item
);

	assign in_ready = !status.clearing && !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		q_item.is_ctrl   = cmd;
		q_item.data      = value_in[7:0];
		q_item.hold_cs   = hold_cs;
		q_item.slot_mode = slot_mode;
		// only the control path looks at whether the whole word is zero
		q_item.word_zero = (value_in == '0);
	end

endmodule

/* design/sbma_queue.sv */
// short fifo between the front end and the back end
module sbma_queue import sbma_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* design/sbma_back.sv */
// back end: command state, address reduction pipeline, save store and result register
module sbma_back import sbma_pkg::*; #(
	parameter int unsigned SAVE_DEPTH = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  item_t        q_item,
	output logic         q_pop,
	output back_status_t status,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   read_byte
);

	localparam int unsigned IW    = $clog2(SAVE_DEPTH);
	localparam int unsigned AW1   = ADDR_W + 1;
	localparam int unsigned SHIFT = ADDR_W + IW;
	localparam int unsigned PW1   = ADDR_W + RECIP_W;
	localparam int unsigned PW2   = ADDR_W + AW1;
	localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((64'd1 << SHIFT) / 64'(SAVE_DEPTH));
	localparam logic [AW1-1:0]     DEPTH_C = AW1'(SAVE_DEPTH);
	localparam logic [IW-1:0]      LAST_IDX = IW'(SAVE_DEPTH - 1);

	// command state
	logic [7:0]        cur_op_q, cur_op_d;
	logic              we_q, we_d;
	logic [7:0]        status_q, status_d;
	logic [1:0]        alen_q, alen_d;
	logic [1:0]        abt_q, abt_d;
	logic [ADDR_W-1:0] ba_q, ba_d;
	logic              det_q, det_d;
	logic [15:0]       dc_q, dc_d;
	logic              pcs_q, pcs_d;
	logic              pcz_q, pcz_d;
	logic              arm_q, arm_d;

	// results of the exec step
	logic [7:0]        res_x;
	logic              mrd_x;
	logic              mwr_x;
	logic [ADDR_W-1:0] addr_x;

	// store clearing after reset
	logic          clr_q;
	logic [IW-1:0] clr_cnt_q;

	// pipeline
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [7:0]        res_s1, res_s2, res_s3, res_s4;
	logic              mrd_s1, mrd_s2, mrd_s3, mrd_s4;
	logic              mwr_s1, mwr_s2, mwr_s3;
	logic [7:0]        wd_s1, wd_s2, wd_s3;
	logic [ADDR_W-1:0] addr_s1, addr_s2, addr_s3;
	logic [ADDR_W-1:0] quo_s2;
	logic [AW1-1:0]    prod_s3;
	logic [7:0]        rd_s4;

	logic [PW1-1:0]    recip_prod;
	logic [PW2-1:0]    depth_prod;
	logic [AW1-1:0]    rem;
	logic [AW1-1:0]    rem_fix;
	logic [IW-1:0]     idx;
	logic              advance;

	logic [7:0] save_store [SAVE_DEPTH];

	logic              out_valid_q;
	logic [7:0]        out_q;

	logic [15:0]       dc_inc;
	logic [ADDR_W-1:0] acc_addr;

	assign advance    = !v_s4 || !out_valid_q || out_ready;
	assign q_pop      = q_valid && !clr_q && advance;
	assign status.clearing = clr_q;
	assign out_valid  = out_valid_q;
	assign read_byte  = out_q;

	assign dc_inc   = dc_q + 16'd1;
	assign acc_addr = (alen_q == 2'd1) ? (ba_q & ADDR_ONE_BYTE_MASK) : ba_q;

	always_comb begin
		cur_op_d = cur_op_q;
		we_d     = we_q;
		status_d = status_q;
		alen_d   = alen_q;
		abt_d    = abt_q;
		ba_d     = ba_q;
		det_d    = det_q;
		dc_d     = dc_q;
		pcs_d    = pcs_q;
		pcz_d    = pcz_q;
		arm_d    = arm_q;
		res_x    = q_item.data;
		mrd_x    = 1'b0;
		mwr_x    = 1'b0;
		addr_x   = acc_addr;
		if (q_item.is_ctrl) begin
			// chip select release, or a fresh select from a zero control word
			if ((!q_item.hold_cs && pcs_q) ||
			    (q_item.slot_mode && pcz_q && !q_item.hold_cs)) begin
				arm_d = 1'b1;
			end
			pcs_d = q_item.hold_cs;
			pcz_d = q_item.word_zero;
		end else begin
			unique case (cur_op_q) inside
				OP_WRSR: begin
					status_d = q_item.data & STATUS_MASK;
				end
				OP_WRITE, OP_READ: begin
					if (det_q) begin
						// first burst only counts bytes to learn the address length
						res_x = BYTE_ERASED;
						dc_d  = dc_inc;
						if (arm_q) begin
							det_d = 1'b0;
							dc_d  = '0;
							if (dc_inc <= 16'd2) begin
								alen_d = 2'd1;
							end else if (dc_inc == 16'd3) begin
								alen_d = 2'd2;
							end else if (dc_inc == 16'd4) begin
								alen_d = 2'd3;
							end else begin
								alen_d = dc_inc[1:0];
							end
						end
					end else if (abt_q < alen_q) begin
						res_x = BYTE_ERASED;
						ba_d  = {ba_q[ADDR_W-9:0], q_item.data};
						abt_d = abt_q + 2'd1;
					end else begin
						if (cur_op_q == OP_READ) begin
							mrd_x = 1'b1;
						end else if (we_q) begin
							mwr_x = 1'b1;
						end
						ba_d = acc_addr + ADDR_W'(1);
					end
				end
				OP_RDSR: begin
					res_x = status_q | (we_q ? STATUS_WEL : 8'h00);
				end
				OP_IRDA: begin
					res_x = BYTE_IRDA;
				end
				OP_IDLE: begin
					res_x    = BYTE_ERASED;
					cur_op_d = q_item.data;
					unique case (q_item.data) inside
						OP_IRDA: res_x = BYTE_IRDA;
						OP_WRDI: we_d = 1'b0;
						OP_WREN: we_d = 1'b1;
						OP_WRITE, OP_READ: begin
							abt_d = '0;
							ba_d  = '0;
						end
						OP_WRHI, OP_RDHI: begin
							cur_op_d = (q_item.data == OP_WRHI) ? OP_WRITE : OP_READ;
							abt_d    = '0;
							// one address byte then selects the upper page
							ba_d     = (alen_q == 2'd1) ? ADDR_W'(1) : '0;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
			if (arm_q) begin
				cur_op_d = OP_IDLE;
				arm_d    = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_op_q <= OP_IDLE;
			we_q     <= 1'b0;
			status_q <= '0;
			alen_q   <= '0;
			abt_q    <= '0;
			ba_q     <= '0;
			det_q    <= 1'b1;
			dc_q     <= '0;
			pcs_q    <= 1'b0;
			pcz_q    <= 1'b1;
			arm_q    <= 1'b0;
		end else if (q_pop) begin
			cur_op_q <= cur_op_d;
			we_q     <= we_d;
			status_q <= status_d;
			alen_q   <= alen_d;
			abt_q    <= abt_d;
			ba_q     <= ba_d;
			det_q    <= det_d;
			dc_q     <= dc_d;
			pcs_q    <= pcs_d;
			pcz_q    <= pcz_d;
			arm_q    <= arm_d;
		end
	end

	// address modulo store depth: reciprocal multiply, back multiply, one correction
	assign recip_prod = PW1'(addr_s1) * PW1'(RECIP);
	assign depth_prod = PW2'(quo_s2) * PW2'(DEPTH_C);
	assign rem        = AW1'(addr_s3) - prod_s3;
	assign rem_fix    = (rem >= DEPTH_C) ? (rem - DEPTH_C) : rem;
	assign idx        = rem_fix[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			clr_q       <= 1'b1;
			clr_cnt_q   <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == LAST_IDX) begin
					clr_q <= 1'b0;
				end
			end
			if (advance) begin
				v_s1 <= q_pop && !q_item.is_ctrl;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
			if (advance && v_s4) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s1  <= res_x;
			mrd_s1  <= mrd_x;
			mwr_s1  <= mwr_x;
			wd_s1   <= q_item.data;
			addr_s1 <= addr_x;
			res_s2  <= res_s1;
			mrd_s2  <= mrd_s1;
			mwr_s2  <= mwr_s1;
			wd_s2   <= wd_s1;
			addr_s2 <= addr_s1;
			quo_s2  <= ADDR_W'(recip_prod >> SHIFT);
			res_s3  <= res_s2;
			mrd_s3  <= mrd_s2;
			mwr_s3  <= mwr_s2;
			wd_s3   <= wd_s2;
			addr_s3 <= addr_s2;
			prod_s3 <= AW1'(depth_prod);
			res_s4  <= res_s3;
			mrd_s4  <= mrd_s3;
		end
		if (advance && v_s4) begin
			out_q <= mrd_s4 ? rd_s4 : res_s4;
		end
	end

	// single port save store
	always_ff @(posedge clk) begin
		if (clr_q) begin
			save_store[clr_cnt_q] <= BYTE_ERASED;
		end else if (advance && v_s3 && mwr_s3) begin
			save_store[idx] <= wd_s3;
		end
		if (advance && v_s3) begin
			rd_s4 <= save_store[idx];
		end
	end

endmodule

/* design/spi_backup_memory_autodetect_top.sv */
// top level of the spi backup memory slave with address length autodetect
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready cmd value_in hold_cs    | to block
//          | slot_mode                                 |
//  out     | out_valid out_ready read_byte             | from block
//
// one transfer per cycle on both channels while out_ready is high and no clearing runs; a data byte
// reaches read_byte via the queue, the four-stage address modulo and store path and the result register
// after reset all SAVE_DEPTH store entries are swept to 0xff, one a cycle, with in_ready low
// a four-entry queue parts intake from execution, so in_ready stays high while the queue has room,
// also while the result register waits on out_ready; control writes give no result
module spi_backup_memory_autodetect_top import sbma_pkg::*; #(
	parameter int unsigned SAVE_DEPTH = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [WORD_W-1:0] value_in,
	input  logic              hold_cs,
	input  logic              slot_mode,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        read_byte
);

	back_status_t status;
	logic         q_full;
	logic         q_push;
	item_t        push_item;
	logic         q_pop;
	logic         head_valid;
	item_t        head_item;

	sbma_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.value_in  (value_in),
		.hold_cs   (hold_cs),
		.slot_mode (slot_mode),
		.status    (status),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	sbma_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	sbma_back #(
		.SAVE_DEPTH (SAVE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (head_valid),
		.q_item    (head_item),
		.q_pop     (q_pop),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_byte (read_byte)
	);

endmodule
